FILE: rtl/kti_pkg.sv
// Shared types and constants for the keyframe track interpolator.
package kti_pkg;

	// Field widths
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned VAL_W       = 32;
	localparam int unsigned FRAC_W      = 16;
	localparam int unsigned SEG_W       = 6;
	localparam int unsigned KEY_IDX_W   = 6;
	localparam int unsigned NUM_KEYS_W  = 7;
	localparam int unsigned STATUS_W    = 2;

	// Default track depth
	localparam int unsigned MAX_KEYS_DEF = 64;

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] ST_PAST_LAST    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_SPAN    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BEFORE_FIRST = 2'd3;

	typedef struct packed {
		logic                        operation;
		logic [KEY_IDX_W-1:0]        key_index;
		logic [TIME_W-1:0]           key_time;
		logic signed [VAL_W-1:0]     key_x;
		logic signed [VAL_W-1:0]     key_y;
		logic signed [VAL_W-1:0]     key_z;
		logic [TIME_W-1:0]           query_time;
	} req_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]     out_x;
		logic signed [VAL_W-1:0]     out_y;
		logic signed [VAL_W-1:0]     out_z;
		logic [SEG_W-1:0]            segment;
		logic [STATUS_W-1:0]         status;
	} rsp_item_t;

	// One stored key as it sits in the key memory
	typedef struct packed {
		logic [TIME_W-1:0]           ktime;
		logic signed [VAL_W-1:0]     kx;
		logic signed [VAL_W-1:0]     ky;
		logic signed [VAL_W-1:0]     kz;
	} key_entry_t;

endpackage

FILE: rtl/kti_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kti_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/kti_div.sv
// Radix-2 restoring divider for the interpolation factor (fraction-only quotient).
module kti_div #(
	parameter int unsigned DW = kti_pkg::TIME_W,
	parameter int unsigned QW = kti_pkg::FRAC_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quo
);

	localparam int unsigned CW = (QW > 1) ? $clog2(QW) : 1;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] quo_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;
	logic          take;

	// One quotient bit per cycle
	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, den_q};
	assign take    = (shifted >= {1'b0, den_q});

	// Sequence the steps and flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? diff[DW-1:0] : shifted[DW-1:0];
			quo_q <= {quo_q[QW-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: rtl/keyframe_track_interpolator_core.sv
// Key write: stored at the accept edge, no result; the next item is taken in the next cycle.
// Query: key scan (one key memory read per cycle), radix-2 division for the factor in 16
// steps, shared multiply and add per component, then the output register, which waits while
// a held result is stalled; a clamped, zero-span or single-key query skips the division and
// blend steps. One query at a time; the output register lets the next item in while a result
// waits. Reset clears control and sets num_keys to 1; key memory stays undefined.
module keyframe_track_interpolator_core #(
	parameter int unsigned MAX_KEYS = kti_pkg::MAX_KEYS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  kti_pkg::req_item_t                  req_data,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output kti_pkg::rsp_item_t                  rsp_data,
	input  logic                                cfg_we,
	input  logic [kti_pkg::NUM_KEYS_W-1:0]      cfg_wdata
);

	import kti_pkg::*;

	localparam int unsigned AW     = $clog2(MAX_KEYS);
	localparam int unsigned PROD_W = FRAC_W + 1 + VAL_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DIV,
		S_MUL,
		S_ADD,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		COMP_X,
		COMP_Y,
		COMP_Z
	} comp_t;

	state_t                    state_q;
	comp_t                     comp_q;
	logic [NUM_KEYS_W-1:0]     num_keys_q;
	logic [AW-1:0]             idx_q;
	logic [AW-1:0]             n_last_q;
	logic [AW-1:0]             n_last_d;
	logic [TIME_W-1:0]         t_q;
	key_entry_t                prev_q;
	key_entry_t                end_q;
	logic [FRAC_W-1:0]         factor_q;
	logic signed [PROD_W-1:0]  prod_q;
	rsp_item_t                 res_q;
	rsp_item_t                 rsp_q;
	logic                      rsp_valid_q;

	logic                      accept;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	key_entry_t                ram_wdata;
	logic                      ram_re;
	logic [AW-1:0]             ram_raddr;
	key_entry_t                rd_entry;
	logic                      hit;
	logic                      zero_span;
	logic                      div_start;
	logic                      div_done;
	logic [FRAC_W-1:0]         div_quo;
	logic signed [VAL_W-1:0]   comp_a;
	logic signed [VAL_W-1:0]   comp_b;
	logic signed [VAL_W:0]     comp_d;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [VAL_W-1:0]   blend_d;

	// Result that hands back a stored key unchanged
	function automatic rsp_item_t key_result(input key_entry_t e, input logic [SEG_W-1:0] seg,
		input logic [STATUS_W-1:0] st);
		rsp_item_t r;
		r.out_x   = e.kx;
		r.out_y   = e.ky;
		r.out_z   = e.kz;
		r.segment = seg;
		r.status  = st;
		return r;
	endfunction

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);

	// Clamp the key count to 1..MAX_KEYS, kept as the last valid index
	always_comb begin
		if (num_keys_q == '0) begin
			n_last_d = '0;
		end else if (32'(num_keys_q) >= 32'(MAX_KEYS)) begin
			n_last_d = AW'(MAX_KEYS - 1);
		end else begin
			n_last_d = AW'(num_keys_q - 1'b1);
		end
	end

	// Key writes go straight into the memory; slots at or past MAX_KEYS are dropped
	assign ram_we    = accept && (req_data.operation == OP_WRITE)
		&& (32'(req_data.key_index) < 32'(MAX_KEYS));
	assign ram_waddr = AW'(req_data.key_index);
	assign ram_wdata = '{ktime: req_data.key_time, kx: req_data.key_x,
		ky: req_data.key_y, kz: req_data.key_z};

	// Read key 0 on a query accept, then one key ahead per scan cycle
	assign ram_re    = (accept && (req_data.operation == OP_QUERY)) || (state_q == S_SCAN);
	assign ram_raddr = (state_q == S_SCAN) ? AW'(idx_q + 1'b1) : '0;

	kti_ram #(
		.WIDTH ($bits(key_entry_t)),
		.DEPTH (MAX_KEYS)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_entry)
	);

	// Segment test on the key just read against the one before
	assign hit       = (t_q < rd_entry.ktime);
	assign zero_span = (rd_entry.ktime <= prev_q.ktime) || (t_q < prev_q.ktime);
	assign div_start = (state_q == S_SCAN) && (idx_q != '0) && hit && !zero_span;

	kti_div #(
		.DW (TIME_W),
		.QW (FRAC_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (t_q - prev_q.ktime),
		.den    (rd_entry.ktime - prev_q.ktime),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Pick the component for the shared multiplier
	always_comb begin
		case (comp_q)
			COMP_Y: begin
				comp_a = prev_q.ky;
				comp_b = end_q.ky;
			end
			COMP_Z: begin
				comp_a = prev_q.kz;
				comp_b = end_q.kz;
			end
			default: begin
				comp_a = prev_q.kx;
				comp_b = end_q.kx;
			end
		endcase
	end

	// Blend: start + floor(factor * (end - start) / 2^16)
	assign comp_d  = {comp_b[VAL_W-1], comp_b} - {comp_a[VAL_W-1], comp_a};
	assign prod_d  = $signed({1'b0, factor_q}) * comp_d;
	assign blend_d = comp_a + prod_q[FRAC_W+VAL_W-1:FRAC_W];

	// Control sequence, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			comp_q      <= COMP_X;
			num_keys_q  <= NUM_KEYS_W'(1);
			idx_q       <= '0;
			n_last_q    <= '0;
			t_q         <= '0;
			prev_q      <= '0;
			end_q       <= '0;
			factor_q    <= '0;
			prod_q      <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_keys_q <= cfg_wdata;
			end
			// Drop the taken result unless a new one is loaded this cycle
			if (rsp_valid_q && !rsp_stall && (state_q != S_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (req_data.operation == OP_QUERY)) begin
						t_q      <= req_data.query_time;
						idx_q    <= '0;
						n_last_q <= n_last_d;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q == '0) begin
						if (n_last_q == '0) begin
							res_q   <= key_result(rd_entry, '0, ST_OK);
							state_q <= S_FIN;
						end else if (hit) begin
							res_q   <= key_result(rd_entry, '0, ST_BEFORE_FIRST);
							state_q <= S_FIN;
						end else begin
							prev_q <= rd_entry;
							idx_q  <= idx_q + 1'b1;
						end
					end else if (hit) begin
						if (zero_span) begin
							res_q   <= key_result(prev_q, SEG_W'(idx_q - 1'b1), ST_ZERO_SPAN);
							state_q <= S_FIN;
						end else begin
							end_q          <= rd_entry;
							res_q.segment  <= SEG_W'(idx_q - 1'b1);
							res_q.status   <= ST_OK;
							state_q        <= S_DIV;
						end
					end else if (idx_q == n_last_q) begin
						res_q   <= key_result(rd_entry, SEG_W'(idx_q), ST_PAST_LAST);
						state_q <= S_FIN;
					end else begin
						prev_q <= rd_entry;
						idx_q  <= idx_q + 1'b1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						factor_q <= div_quo;
						comp_q   <= COMP_X;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= prod_d;
					state_q <= S_ADD;
				end
				S_ADD: begin
					case (comp_q)
						COMP_X: begin
							res_q.out_x <= blend_d;
							comp_q      <= COMP_Y;
							state_q     <= S_MUL;
						end
						COMP_Y: begin
							res_q.out_y <= blend_d;
							comp_q      <= COMP_Z;
							state_q     <= S_MUL;
						end
						default: begin
							res_q.out_z <= blend_d;
							state_q     <= S_FIN;
						end
					endcase
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

FILE: rtl/kti_checker.sv
// Port-level assertions for the keyframe track interpolator, bound to the top level.
module kti_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_stall,
	input kti_pkg::req_item_t             req_data,
	input logic                           rsp_valid,
	input logic                           rsp_stall,
	input kti_pkg::rsp_item_t             rsp_data,
	input logic                           cfg_we,
	input logic [kti_pkg::NUM_KEYS_W-1:0] cfg_wdata
);

	import kti_pkg::*;

	logic req_take;

	assign req_take = req_valid && !req_stall;

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// Block further items while a query is at work
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_take && (req_data.operation == OP_QUERY) |=> req_stall)
		else $error("item accepted during a query");

	// No result appears in the cycle right after an item is taken
	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> !$rose(rsp_valid))
		else $error("result raised too early");

	// A clamp before the first key always reports segment zero
	a_before_first_seg: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == ST_BEFORE_FIRST) |-> rsp_data.segment == '0)
		else $error("before-first result with nonzero segment");

	// Write the key count only while idle with no result waiting
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !req_stall && !rsp_valid && !$isunknown(cfg_wdata))
		else $error("key count written while busy");

endmodule

bind keyframe_track_interpolator_core kti_checker u_kti_checker (.*);

FILE: tb/kti_track_checker.sv
// Checker for the keyframe track interpolator: watches both channels, predicts and compares.
module kti_track_checker #(
	parameter int unsigned MAX_KEYS = kti_pkg::MAX_KEYS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic                            req_stall,
	input  kti_pkg::req_item_t              req_data,
	input  logic                            rsp_valid,
	input  logic                            rsp_stall,
	input  kti_pkg::rsp_item_t              rsp_data,
	input  logic                            cfg_we,
	input  logic [kti_pkg::NUM_KEYS_W-1:0]  cfg_wdata,
	output int                              errors,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import kti_pkg::*;

	// Shadow of the key memory and the key count register
	key_entry_t            track_keys [MAX_KEYS];
	logic [NUM_KEYS_W-1:0] key_count_reg = NUM_KEYS_W'(1);

	// Interpolated samples owed by the block, oldest first
	rsp_item_t queued_samples [$];
	rsp_item_t oldest_sample;
	int        mismatch_count = 0;

	initial pending = 0;
	assign errors = mismatch_count;

	// Stored key returned unchanged, as for clamped, zero-span and single-key queries
	function automatic rsp_item_t held_key(input int unsigned k, input logic [STATUS_W-1:0] st);
		rsp_item_t r;
		r.out_x   = track_keys[k].kx;
		r.out_y   = track_keys[k].ky;
		r.out_z   = track_keys[k].kz;
		r.segment = SEG_W'(k);
		r.status  = st;
		return r;
	endfunction

	// start + floor(f * (end - start) / 2^16)
	function automatic logic signed [VAL_W-1:0] lerp(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b, input logic [FRAC_W-1:0] f);
		longint span_v;
		longint prod;
		span_v = longint'(b) - longint'(a);
		prod   = longint'({1'b0, f}) * span_v;
		return a + VAL_W'(prod >>> FRAC_W);
	endfunction

	// Scan for the segment holding t and blend its two keys, or return a held key
	function automatic rsp_item_t sample_track(input logic [TIME_W-1:0] t);
		rsp_item_t        r;
		int unsigned      n;
		logic [TIME_W-1:0] delta;
		logic [TIME_W-1:0] width;
		logic [63:0]      frac;
		n = (key_count_reg == 0) ? 1 : ((key_count_reg > MAX_KEYS) ? MAX_KEYS : key_count_reg);
		if (n == 1)
			return held_key(0, ST_OK);
		if (t < track_keys[0].ktime)
			return held_key(0, ST_BEFORE_FIRST);
		for (int unsigned i = 0; i + 1 < n; i++) begin
			if (t < track_keys[i+1].ktime) begin
				if (track_keys[i+1].ktime <= track_keys[i].ktime || t < track_keys[i].ktime)
					return held_key(i, ST_ZERO_SPAN);
				delta = t - track_keys[i].ktime;
				width = track_keys[i+1].ktime - track_keys[i].ktime;
				frac  = ({32'd0, delta} << FRAC_W) / {32'd0, width};
				if (frac > 64'hFFFF)
					frac = 64'hFFFF;
				r.out_x   = lerp(track_keys[i].kx, track_keys[i+1].kx, frac[FRAC_W-1:0]);
				r.out_y   = lerp(track_keys[i].ky, track_keys[i+1].ky, frac[FRAC_W-1:0]);
				r.out_z   = lerp(track_keys[i].kz, track_keys[i+1].kz, frac[FRAC_W-1:0]);
				r.segment = SEG_W'(i);
				r.status  = ST_OK;
				return r;
			end
		end
		return held_key(n - 1, ST_PAST_LAST);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s mismatch: expected 0x%08h, got 0x%08h", name, want_v, got_v);
			mismatch_count++;
		end
	endtask

	// Track config and key writes, queue predictions, compare each accepted result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_reg = NUM_KEYS_W'(1);
			queued_samples.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				key_count_reg = cfg_wdata;
			if (req_valid && !req_stall) begin
				if (req_data.operation == OP_WRITE) begin
					if (req_data.key_index < MAX_KEYS)
						track_keys[req_data.key_index] = '{req_data.key_time, req_data.key_x,
							req_data.key_y, req_data.key_z};
				end else begin
					queued_samples = {queued_samples, sample_track(req_data.query_time)};
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (queued_samples.size() == 0) begin
					$error("result item with no query outstanding");
					mismatch_count++;
				end else begin
					oldest_sample = queued_samples.pop_front();
					check_field("out_x", oldest_sample.out_x, rsp_data.out_x);
					check_field("out_y", oldest_sample.out_y, rsp_data.out_y);
					check_field("out_z", oldest_sample.out_z, rsp_data.out_z);
					check_field("segment", 32'(oldest_sample.segment), 32'(rsp_data.segment));
					check_field("status", 32'(oldest_sample.status), 32'(rsp_data.status));
				end
			end
			pending <= queued_samples.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the keyframe track interpolator: stimulus, handshakes and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import kti_pkg::*;

	localparam int unsigned MAX_KEYS      = MAX_KEYS_DEF;
	localparam int unsigned GAP_MAX       = 18;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned DRAIN_CYCLES  = MAX_KEYS + 40;
	localparam int unsigned ITEM_TARGET   = 450;
	localparam longint      RUN_LIMIT_NS  = 64'd12_000_000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	req_item_t             req_data;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_item_t             rsp_data;
	logic                  cfg_we;
	logic [NUM_KEYS_W-1:0] cfg_wdata;
	int                    fail_total;
	int                    samples_owed;

	logic [TIME_W-1:0] track_time [MAX_KEYS];
	int unsigned       live_keys = 1;
	int unsigned       item_count = 0;
	bit                no_idle = 1'b0;

	keyframe_track_interpolator_core #(.MAX_KEYS(MAX_KEYS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	kti_track_checker #(.MAX_KEYS(MAX_KEYS)) u_track_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (fail_total),
		.pending   (samples_owed)
	);

	always #6 clk = ~clk;

	// Wait length for one item on either side; none during quiet phases
	function automatic int unsigned idle_cycles();
		if (no_idle || $urandom_range(0, 4) == 0)
			return 0;
		return $urandom_range(0, GAP_MAX);
	endfunction

	// Mostly full-range values, some small ones and the extremes
	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 7);
		if (r < 4)
			return $urandom();
		if (r < 6)
			return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			default: return 32'h0000_0000;
		endcase
	endfunction

	// Times before, on, inside and past the stored keys
	function automatic logic [TIME_W-1:0] pick_query_time();
		int unsigned       sel;
		int unsigned       j;
		logic [TIME_W-1:0] first;
		logic [TIME_W-1:0] last;
		first = track_time[0];
		last  = track_time[live_keys-1];
		sel   = $urandom_range(0, 99);
		j     = $urandom_range(0, live_keys - 1);
		if (sel < 8)
			return $urandom();
		if (sel < 18)
			return (first == 0) ? 32'd0 : $urandom_range(0, first - 1);
		if (sel < 28)
			return (last == 0) ? $urandom() : $urandom_range(last, 32'hFFFF_FFFF);
		if (sel < 43)
			return track_time[j];
		if (j + 1 < live_keys && track_time[j+1] > track_time[j])
			return $urandom_range(track_time[j], track_time[j+1] - 1);
		return track_time[j] + $urandom_range(0, 3);
	endfunction

	function automatic logic [NUM_KEYS_W-1:0] pick_key_count(input int unsigned phase);
		int unsigned r;
		if (phase == 0)
			return 7'd127;
		if (phase == 1)
			return 7'd64;
		if (phase == 2)
			return 7'd2;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 7'($urandom_range(2, 8));
		if (r < 8)
			return 7'($urandom_range(9, 40));
		if (r < 9)
			return 7'($urandom_range(0, 1));
		return 7'($urandom_range(65, 126));
	endfunction

	// Present one item after a random gap and hold it until accepted
	task automatic send_item(input req_item_t it);
		int unsigned gap;
		gap = idle_cycles();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= it;
		do @(posedge clk); while (req_stall);
		item_count++;
	endtask

	task automatic write_key(input int unsigned slot, input logic [TIME_W-1:0] t,
			input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y, input logic [VAL_W-1:0] z);
		req_item_t it;
		it.operation  = OP_WRITE;
		it.key_index  = KEY_IDX_W'(slot);
		it.key_time   = t;
		it.key_x      = x;
		it.key_y      = y;
		it.key_z      = z;
		it.query_time = $urandom();
		track_time[slot] = t;
		send_item(it);
	endtask

	task automatic query_at(input logic [TIME_W-1:0] t);
		req_item_t it;
		it.operation  = OP_QUERY;
		it.key_index  = KEY_IDX_W'($urandom_range(0, 63));
		it.key_time   = $urandom();
		it.key_x      = $urandom();
		it.key_y      = $urandom();
		it.key_z      = $urandom();
		it.query_time = t;
		send_item(it);
	endtask

	// Drop valid and hold until every owed result has been taken
	task automatic wait_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (samples_owed != 0) @(posedge clk);
	endtask

	task automatic set_key_count(input logic [NUM_KEYS_W-1:0] v);
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		live_keys = (v == 0) ? 1 : ((v > MAX_KEYS) ? MAX_KEYS : v);
	endtask

	// Write a full ascending track of n keys: wide, compact, with repeated times, or high
	task automatic build_track(input int unsigned n);
		int unsigned       style;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] step_max;
		logic [TIME_W-1:0] step;
		style = $urandom_range(0, 3);
		if (style == 0) begin
			t        = $urandom_range(0, 32'h7FFF_FFFF);
			step_max = (32'hFFFF_FFFF - t) / n;
		end else if (style == 1) begin
			t        = $urandom_range(0, 32'h0004_0000);
			step_max = 32'h0003_0000;
		end else if (style == 2) begin
			t        = $urandom_range(0, 32'h0010_0000);
			step_max = 32'h0000_0100;
		end else begin
			t        = $urandom_range(32'h8000_0000, 32'hFFF0_0000);
			step_max = (32'hFFFF_FFFF - t) / n;
		end
		for (int unsigned k = 0; k < n; k++) begin
			write_key(k, t, pick_value(), pick_value(), pick_value());
			step = (style == 2 && $urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, step_max);
			t    = t + step;
		end
	endtask

	// Result side: stall a random time once a result shows, then take it
	initial begin : rsp_sink
		int unsigned hold;
		rsp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = idle_cycles();
			rsp_stall <= (hold != 0);
			if (hold != 0) begin
				do @(posedge clk); while (!rsp_valid);
				repeat (hold - 1) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
		end
	end

	// Request side: directed cases, then random phases of track build and queries
	initial begin : stimulus
		int unsigned phase;
		int unsigned r;
		int unsigned slot;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_data  <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single key after reset, then a zero count acting as one
		write_key(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		query_at(32'h0000_0000);
		query_at(32'hFFFF_FFFF);
		set_key_count(7'd0);
		query_at(32'h0002_0000);

		// Three keys spanning the whole time range with extreme values
		set_key_count(7'd3);
		write_key(1, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_8000);
		write_key(2, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000);
		query_at(32'h0000_0000);
		query_at(32'h0001_0000);
		query_at(32'h0001_8000);
		query_at(32'h0001_FFFF);
		query_at(32'h0002_0000);
		query_at(32'h8000_0000);
		query_at(32'hFFFF_FFFE);
		query_at(32'hFFFF_FFFF);

		// Repeated key time: zero-length segment must be skipped
		write_key(1, 32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		query_at(32'h0001_0000);
		query_at(32'h0000_FFFF);

		phase = 0;
		while (item_count < ITEM_TARGET) begin
			no_idle = ($urandom_range(0, 3) == 0);
			set_key_count(pick_key_count(phase));
			build_track(live_keys);
			repeat ($urandom_range(15, 40)) begin
				// Now and then let the block drain completely
				if ($urandom_range(0, 24) == 0)
					wait_results();
				r = $urandom_range(0, 99);
				if (r < 82) begin
					query_at(pick_query_time());
				end else if (r < 91) begin
					slot = $urandom_range(0, live_keys - 1);
					write_key(slot, track_time[slot], pick_value(), pick_value(), pick_value());
				end else begin
					// Overwrite any slot with any time, possibly breaking the order
					write_key($urandom_range(0, 63), $urandom(), pick_value(), pick_value(),
						pick_value());
				end
			end
			phase++;
		end

		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_total == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hard stop if the run hangs
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("FAIL");
		$finish;
	end

endmodule
